### sv/obpl_pkg.sv
// Shared constants and types for the order book price level tables.
// Used by obpl_cell, obpl_side, order_book_price_levels_top and obpl_checker.
package obpl_pkg;

  localparam int LEVELS     = 64;
  localparam int PRICE_BITS = 40;
  localparam int QTY_BITS   = 48;

  // Command broadcast to every cell of one side in a cycle.
  typedef enum logic [2:0] {
    CMD_HOLD    = 3'd0,
    CMD_CMP     = 3'd1,
    CMD_CLEAR   = 3'd2,
    CMD_INSERT  = 3'd3,
    CMD_REMOVE  = 3'd4,
    CMD_SET_QTY = 3'd5
  } cell_cmd_t;

  // Registered compare result of a cell against the request key.
  typedef struct packed {
    logic pgt;  // key sorts ahead of this cell, or the cell is empty
    logic eq;   // cell holds the key
  } cell_flag_t;

  // Control from the top level to one side.
  typedef struct packed {
    logic cmp;
    logic apply;
    logic clear;
    logic sel;
    logic qty_zero;
  } side_req_t;

  // Status from one side back to the top level.
  typedef struct packed {
    logic dropped;
    logic head_valid;
  } side_sts_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CMP   = 3'b010,
    S_APPLY = 3'b100
  } state_t;

endpackage

### sv/obpl_cell.sv
// One price level cell of a sorted chain; it trades contents with its neighbors.
// Depends on obpl_pkg for the command and flag types.
module obpl_cell #(
  parameter int PRICE_BITS = obpl_pkg::PRICE_BITS,
  parameter int QTY_BITS   = obpl_pkg::QTY_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  obpl_pkg::cell_cmd_t    cmd,
  input  logic [PRICE_BITS-1:0]  key,
  input  logic [QTY_BITS-1:0]    qty_in,
  input  logic                   prev_valid,
  input  logic [PRICE_BITS-1:0]  prev_price,
  input  logic [QTY_BITS-1:0]    prev_qty,
  input  logic                   prev_pgt,
  input  logic                   next_valid,
  input  logic [PRICE_BITS-1:0]  next_price,
  input  logic [QTY_BITS-1:0]    next_qty,
  output logic                   valid,
  output logic [PRICE_BITS-1:0]  price,
  output logic [QTY_BITS-1:0]    qty,
  output obpl_pkg::cell_flag_t   flag,
  output logic                   valid_nxt,
  output logic [PRICE_BITS-1:0]  price_nxt
);

  logic                  valid_r;
  logic [PRICE_BITS-1:0] price_r;
  logic [QTY_BITS-1:0]   qty_r;
  logic [QTY_BITS-1:0]   qty_nxt;
  obpl_pkg::cell_flag_t  flag_r;
  obpl_pkg::cell_flag_t  flag_nxt;

  always_comb begin
    valid_nxt = valid_r;
    price_nxt = price_r;
    qty_nxt   = qty_r;
    flag_nxt  = flag_r;
    unique case (cmd)
      obpl_pkg::CMD_HOLD: begin
      end
      obpl_pkg::CMD_CMP: begin
        flag_nxt.pgt = !valid_r || (key > price_r);
        flag_nxt.eq  = valid_r && (key == price_r);
      end
      obpl_pkg::CMD_CLEAR: begin
        valid_nxt = 1'b0;
      end
      obpl_pkg::CMD_INSERT: begin
        // Cells behind the insertion point shift one place down the chain.
        if (flag_r.pgt) begin
          if (prev_pgt) begin
            valid_nxt = prev_valid;
            price_nxt = prev_price;
            qty_nxt   = prev_qty;
          end else begin
            valid_nxt = 1'b1;
            price_nxt = key;
            qty_nxt   = qty_in;
          end
        end
      end
      obpl_pkg::CMD_REMOVE: begin
        // The matching cell and all behind it shift one place up the chain.
        if (flag_r.pgt || flag_r.eq) begin
          valid_nxt = next_valid;
          price_nxt = next_price;
          qty_nxt   = next_qty;
        end
      end
      obpl_pkg::CMD_SET_QTY: begin
        if (flag_r.eq) begin
          qty_nxt = qty_in;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      flag_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      flag_r  <= flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    price_r <= price_nxt;
    qty_r   <= qty_nxt;
  end

  assign valid = valid_r;
  assign price = price_r;
  assign qty   = qty_r;
  assign flag  = flag_r;

endmodule

### sv/obpl_side.sv
// One side of the book: a chain of cells kept sorted with the best level at the head.
// Depends on obpl_pkg and obpl_cell.
module obpl_side #(
  parameter int LEVELS     = obpl_pkg::LEVELS,
  parameter int PRICE_BITS = obpl_pkg::PRICE_BITS,
  parameter int QTY_BITS   = obpl_pkg::QTY_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  obpl_pkg::side_req_t    req,
  input  logic [PRICE_BITS-1:0]  key,
  input  logic [QTY_BITS-1:0]    qty_in,
  output obpl_pkg::side_sts_t    sts,
  output logic [PRICE_BITS-1:0]  head_price
);

  logic                  cell_valid [LEVELS];
  logic [PRICE_BITS-1:0] cell_price [LEVELS];
  logic [QTY_BITS-1:0]   cell_qty   [LEVELS];
  obpl_pkg::cell_flag_t  cell_flag  [LEVELS];
  logic                  valid_nxt  [LEVELS];
  logic [PRICE_BITS-1:0] price_nxt  [LEVELS];
  logic                  prev_valid [LEVELS];
  logic [PRICE_BITS-1:0] prev_price [LEVELS];
  logic [QTY_BITS-1:0]   prev_qty   [LEVELS];
  logic                  prev_pgt   [LEVELS];
  logic                  next_valid [LEVELS];
  logic [PRICE_BITS-1:0] next_price [LEVELS];
  logic [QTY_BITS-1:0]   next_qty   [LEVELS];
  logic [LEVELS-1:0]     eq_vec;
  logic                  any_eq;
  logic                  full;
  obpl_pkg::cell_cmd_t   cmd;
  logic                  dropped;

  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_valid[i] = 1'b0;
      assign prev_price[i] = key;
      assign prev_qty[i]   = qty_in;
      assign prev_pgt[i]   = 1'b0;
    end else begin : g_body
      assign prev_valid[i] = cell_valid[i-1];
      assign prev_price[i] = cell_price[i-1];
      assign prev_qty[i]   = cell_qty[i-1];
      assign prev_pgt[i]   = cell_flag[i-1].pgt;
    end
    if (i == LEVELS - 1) begin : g_tail
      assign next_valid[i] = 1'b0;
      assign next_price[i] = key;
      assign next_qty[i]   = qty_in;
    end else begin : g_inner
      assign next_valid[i] = cell_valid[i+1];
      assign next_price[i] = cell_price[i+1];
      assign next_qty[i]   = cell_qty[i+1];
    end

    obpl_cell #(
      .PRICE_BITS (PRICE_BITS),
      .QTY_BITS   (QTY_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .key        (key),
      .qty_in     (qty_in),
      .prev_valid (prev_valid[i]),
      .prev_price (prev_price[i]),
      .prev_qty   (prev_qty[i]),
      .prev_pgt   (prev_pgt[i]),
      .next_valid (next_valid[i]),
      .next_price (next_price[i]),
      .next_qty   (next_qty[i]),
      .valid      (cell_valid[i]),
      .price      (cell_price[i]),
      .qty        (cell_qty[i]),
      .flag       (cell_flag[i]),
      .valid_nxt  (valid_nxt[i]),
      .price_nxt  (price_nxt[i])
    );

    assign eq_vec[i] = cell_flag[i].eq;
  end

  // Valid levels are packed at the head, so the side is full when the tail is valid.
  assign any_eq = |eq_vec;
  assign full   = cell_valid[LEVELS-1];

  always_comb begin
    cmd     = obpl_pkg::CMD_HOLD;
    dropped = 1'b0;
    if (req.cmp) begin
      cmd = obpl_pkg::CMD_CMP;
    end else if (req.apply) begin
      if (req.clear) begin
        cmd = obpl_pkg::CMD_CLEAR;
      end else if (req.sel) begin
        if (any_eq) begin
          cmd = req.qty_zero ? obpl_pkg::CMD_REMOVE : obpl_pkg::CMD_SET_QTY;
        end else if (!req.qty_zero) begin
          if (full) begin
            dropped = 1'b1;
          end else begin
            cmd = obpl_pkg::CMD_INSERT;
          end
        end
      end
    end
  end

  assign sts.dropped    = dropped;
  assign sts.head_valid = valid_nxt[0];
  assign head_price     = price_nxt[0];

endmodule

### sv/order_book_price_levels_top.sv
// Top level of the order book price level tables: request register, sequencer,
// bid and ask chains, result register. Depends on obpl_pkg and obpl_side.
//
//  channel | direction | handshake            | payload
//  in_     | request   | in_valid / in_stall  | op, side, price, qty
//  out_    | result    | out_valid / out_stall| best_bid, best_ask, dropped_full
//
// Each request passes a compare state, in which every cell compares its level with the
// price, and then an apply state, in which the match is gathered across the chain and
// the cells shift. The next request is taken in the apply state of the one before.
// Reset clears every level's valid bit; no clearing pass is needed.
// A stalled result holds the apply cycle until the result register drains.
// Ask prices are stored inverted, so both chains keep the best level at the head.
module order_book_price_levels_top #(
  parameter int LEVELS     = obpl_pkg::LEVELS,
  parameter int PRICE_BITS = obpl_pkg::PRICE_BITS,
  parameter int QTY_BITS   = obpl_pkg::QTY_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  input  logic                  in_side,
  input  logic [PRICE_BITS-1:0] in_price,
  input  logic [QTY_BITS-1:0]   in_qty,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PRICE_BITS-1:0] out_best_bid,
  output logic [PRICE_BITS-1:0] out_best_ask,
  output logic                  out_dropped_full
);

  obpl_pkg::state_t      state_r, state_nxt;
  logic                  op_r;
  logic                  side_r;
  logic [PRICE_BITS-1:0] price_r;
  logic [QTY_BITS-1:0]   qty_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [PRICE_BITS-1:0] best_bid_r;
  logic [PRICE_BITS-1:0] best_ask_r;
  logic                  dropped_r;
  logic                  accept;
  logic                  apply_go;
  logic                  apply_fire;
  obpl_pkg::side_req_t   bid_req, ask_req;
  obpl_pkg::side_sts_t   bid_sts, ask_sts;
  logic [PRICE_BITS-1:0] bid_head, ask_head;

  assign apply_go   = !out_valid_r || !out_stall;
  assign apply_fire = (state_r == obpl_pkg::S_APPLY) && apply_go;
  assign in_stall   = !((state_r == obpl_pkg::S_IDLE) || apply_fire);
  assign accept     = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      obpl_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = obpl_pkg::S_CMP;
        end
      end
      obpl_pkg::S_CMP: begin
        state_nxt = obpl_pkg::S_APPLY;
      end
      obpl_pkg::S_APPLY: begin
        if (apply_go) begin
          state_nxt = accept ? obpl_pkg::S_CMP : obpl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = obpl_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (apply_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= obpl_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_op;
      side_r  <= in_side;
      price_r <= in_price;
      qty_r   <= in_qty;
    end
    if (apply_fire) begin
      best_bid_r <= bid_sts.head_valid ? bid_head : '0;
      best_ask_r <= ask_sts.head_valid ? ~ask_head : '0;
      dropped_r  <= bid_sts.dropped || ask_sts.dropped;
    end
  end

  always_comb begin
    bid_req.cmp      = (state_r == obpl_pkg::S_CMP);
    bid_req.apply    = apply_fire;
    bid_req.clear    = op_r;
    bid_req.sel      = !side_r;
    bid_req.qty_zero = (qty_r == '0);
    ask_req          = bid_req;
    ask_req.sel      = side_r;
  end

  obpl_side #(
    .LEVELS     (LEVELS),
    .PRICE_BITS (PRICE_BITS),
    .QTY_BITS   (QTY_BITS)
  ) u_bid (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (bid_req),
    .key        (price_r),
    .qty_in     (qty_r),
    .sts        (bid_sts),
    .head_price (bid_head)
  );

  obpl_side #(
    .LEVELS     (LEVELS),
    .PRICE_BITS (PRICE_BITS),
    .QTY_BITS   (QTY_BITS)
  ) u_ask (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (ask_req),
    .key        (~price_r),
    .qty_in     (qty_r),
    .sts        (ask_sts),
    .head_price (ask_head)
  );

  assign out_valid        = out_valid_r;
  assign out_best_bid     = best_bid_r;
  assign out_best_ask     = best_ask_r;
  assign out_dropped_full = dropped_r;

endmodule

### sv/obpl_checker.sv
// Port-level checks for order_book_price_levels_top, attached by bind.
// Depends on obpl_pkg for the default price width.
module obpl_checker #(
  parameter int PRICE_BITS = obpl_pkg::PRICE_BITS
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [PRICE_BITS-1:0] out_best_bid,
  input logic [PRICE_BITS-1:0] out_best_ask,
  input logic                  out_dropped_full
);

  // A request is followed by its compare cycle, in which nothing is taken.
  a_one_per_two: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken in the cycle after a request");

  // A request is followed by a result on the output once it has passed the compare and apply states.
  a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> ##3 out_valid)
    else $error("no result after a request");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_best_bid)
      && $stable(out_best_ask) && $stable(out_dropped_full)))
    else $error("stalled result changed");

  // Reset empties the result register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind order_book_price_levels_top obpl_checker #(
  .PRICE_BITS (PRICE_BITS)
) u_obpl_checker (.*);
